// ===== hw/rtl/patf_pkg.sv =====
// Shared constants and types of the phase-angle thyristor firing controller.
`timescale 1ns / 1ps
package patf_pkg;

    localparam int RING_DEPTH     = 20;
    localparam int INTERVAL_WIDTH = 20;

    localparam int POS_W  = $clog2(RING_DEPTH);
    localparam int SUM_W  = INTERVAL_WIDTH + POS_W;
    localparam int DLY_W  = (INTERVAL_WIDTH > 16) ? INTERVAL_WIDTH : 16;
    localparam int SP_W   = 7;
    localparam int PROD_W = INTERVAL_WIDTH + SP_W;
    localparam int OUT_W  = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [SP_W-1:0] SP_MAX = SP_W'(100);

    localparam int CQ_DEPTH = 4;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int RQ_DEPTH = 2;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);

    typedef logic [1:0] t_kind;
    localparam t_kind K_OFF  = 2'd0;
    localparam t_kind K_TICK = 2'd1;
    localparam t_kind K_HOLD = 2'd2;
    localparam t_kind K_FIRE = 2'd3;

    typedef struct packed {
        logic            enable;
        logic [15:0]     pulse_width_us;
        logic [15:0]     min_delay_us;
        logic [SP_W-1:0] fire_threshold;
    } t_cfg;

    typedef struct packed {
        t_kind           kind;
        logic [SP_W-1:0] sp;
    } t_cmd;

    typedef struct packed {
        logic             gate;
        logic [OUT_W-1:0] half_period_avg;
        logic [OUT_W-1:0] firing_delay;
        logic             timer_armed;
    } t_res;

endpackage

// ===== hw/rtl/patf_front.sv =====
// Front end: classifies incoming beats and queues them for the back end.
`timescale 1ns / 1ps
module patf_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    input  logic                    i_mode,
    input  logic [patf_pkg::SP_W-1:0] i_set_point,
    input  patf_pkg::t_cfg          i_cfg,
    output logic                    full,
    output logic                    o_cmd_valid,
    output patf_pkg::t_cmd          o_cmd,
    input  logic                    i_cmd_pop
);
    import patf_pkg::*;

    t_cmd                w_cmd;
    logic                w_push;
    t_cmd                r_q [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] r_wr;
    logic [CQ_PTR_W-1:0] r_rd;
    logic [CQ_PTR_W:0]   r_cnt;
    logic [CQ_PTR_W:0]   n_cnt;

    always_comb begin
        w_cmd.sp = (i_set_point > SP_MAX) ? SP_MAX : i_set_point;
        if (!i_cfg.enable) begin
            w_cmd.kind = K_OFF;
        end else if (!i_mode) begin
            w_cmd.kind = K_TICK;
        end else if (i_set_point > i_cfg.fire_threshold) begin
            w_cmd.kind = K_FIRE;
        end else begin
            w_cmd.kind = K_HOLD;
        end
    end

    assign full        = (r_cnt == (CQ_PTR_W+1)'(CQ_DEPTH));
    assign w_push      = push && !full;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !i_cmd_pop) begin
            n_cnt = r_cnt + (CQ_PTR_W+1)'(1);
        end else if (!w_push && i_cmd_pop) begin
            n_cnt = r_cnt - (CQ_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wr <= r_wr + CQ_PTR_W'(1);
            end
            if (i_cmd_pop) begin
                r_rd <= r_rd + CQ_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_cmd;
        end
    end

endmodule

// ===== hw/rtl/patf_back.sv =====
// Back end: interval ring, averaging, firing delay and gate timing.
`timescale 1ns / 1ps
module patf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  patf_pkg::t_cfg i_cfg,
    input  logic           i_cmd_valid,
    input  patf_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    input  logic           i_res_ready,
    output logic           o_res_valid,
    output patf_pkg::t_res o_res
);
    import patf_pkg::*;

    localparam int IW = INTERVAL_WIDTH;
    localparam logic [SUM_W-1:0]  AVG_RECIP = SUM_W'((64'd1 << SUM_W) / 64'(RING_DEPTH));
    localparam logic [SUM_W-1:0]  DEPTH_S   = SUM_W'(RING_DEPTH);
    localparam logic [PROD_W-1:0] PCT_RECIP = PROD_W'((64'd1 << PROD_W) / 64'd100);
    localparam logic [PROD_W-1:0] PCT_DIV   = PROD_W'(100);

    localparam logic [2:0] ST_RUN = 3'd0;
    localparam logic [2:0] ST_MUL = 3'd1;
    localparam logic [2:0] ST_AVG = 3'd2;
    localparam logic [2:0] ST_DP  = 3'd3;
    localparam logic [2:0] ST_DR  = 3'd4;
    localparam logic [2:0] ST_FIN = 3'd5;

    function automatic logic [OUT_W-1:0] fit_out(input logic [63:0] v);
        fit_out = v[OUT_W-1:0];
    endfunction

    logic [2:0]            r_st, n_st;
    logic [IW-1:0]         r_ring [RING_DEPTH];
    logic [RING_DEPTH-1:0] r_ring_vld;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [SUM_W-1:0]      r_sum, n_sum;
    logic [IW-1:0]         r_since, n_since;
    logic                  r_gate, n_gate;
    logic [DLY_W-1:0]      r_cnt, n_cnt;
    logic                  r_armed, n_armed;
    logic [DLY_W-1:0]      r_last, n_last;
    logic [IW-1:0]         r_avg, n_avg;
    logic [SP_W-1:0]       r_sp;
    logic                  r_fire;
    logic [2*SUM_W-1:0]    r_prod;
    logic [PROD_W-1:0]     r_prod2;
    logic [2*PROD_W-1:0]   r_prod3;

    logic                  w_cross;
    logic [IW-1:0]         w_old;
    logic [IW-1:0]         w_aq;
    logic [SUM_W-1:0]      w_arem;
    logic [IW-1:0]         w_avg;
    logic [IW-1:0]         w_dq;
    logic [PROD_W-1:0]     w_drem;
    logic [IW-1:0]         w_dly1;
    logic [DLY_W-1:0]      w_dly;

    // average: reciprocal multiply, then one correction step
    always_comb begin
        w_aq   = r_prod[SUM_W +: IW];
        w_arem = r_sum - SUM_W'(w_aq) * DEPTH_S;
        w_avg  = w_aq + IW'(w_arem >= DEPTH_S);
        w_dq   = r_prod3[PROD_W +: IW];
        w_drem = r_prod2 - PROD_W'(w_dq) * PCT_DIV;
        w_dly1 = w_dq + IW'(w_drem >= PCT_DIV);
        if (w_dly1 > r_avg) begin
            w_dly1 = r_avg;
        end
        w_dly = DLY_W'(w_dly1);
        if (w_dly < DLY_W'(i_cfg.min_delay_us)) begin
            w_dly = DLY_W'(i_cfg.min_delay_us);
        end
    end

    assign w_old = r_ring_vld[r_pos] ? r_ring[r_pos] : '0;

    always_comb begin
        n_st        = r_st;
        n_pos       = r_pos;
        n_sum       = r_sum;
        n_since     = r_since;
        n_gate      = r_gate;
        n_cnt       = r_cnt;
        n_armed     = r_armed;
        n_last      = r_last;
        n_avg       = r_avg;
        w_cross     = 1'b0;
        o_cmd_pop   = 1'b0;
        o_res_valid = 1'b0;
        unique case (r_st)
            ST_RUN: begin
                if (i_cmd_valid) begin
                    if (i_cmd.kind == K_HOLD || i_cmd.kind == K_FIRE) begin
                        o_cmd_pop = 1'b1;
                        w_cross   = 1'b1;
                        n_sum     = r_sum - SUM_W'(w_old) + SUM_W'(r_since);
                        n_pos     = (r_pos == POS_W'(RING_DEPTH - 1)) ? '0
                                                                       : r_pos + POS_W'(1);
                        n_since   = '0;
                        n_st      = ST_MUL;
                    end else if (i_res_ready) begin
                        o_cmd_pop   = 1'b1;
                        o_res_valid = 1'b1;
                        if (i_cmd.kind == K_OFF) begin
                            n_gate  = 1'b0;
                            n_armed = 1'b0;
                            n_cnt   = '0;
                        end else begin
                            if (r_since != '1) begin
                                n_since = r_since + IW'(1);
                            end
                            if (r_armed) begin
                                if (r_cnt > DLY_W'(1)) begin
                                    n_cnt = r_cnt - DLY_W'(1);
                                end else if (!r_gate) begin
                                    n_gate = 1'b1;
                                    n_cnt  = DLY_W'(i_cfg.pulse_width_us);
                                end else begin
                                    n_gate  = 1'b0;
                                    n_cnt   = '0;
                                    n_armed = 1'b0;
                                end
                            end
                        end
                    end
                end
            end
            ST_MUL: begin
                n_st = ST_AVG;
            end
            ST_AVG: begin
                n_avg = w_avg;
                n_st  = r_fire ? ST_DP : ST_FIN;
            end
            ST_DP: begin
                n_st = ST_DR;
            end
            ST_DR: begin
                n_st = ST_FIN;
            end
            ST_FIN: begin
                if (i_res_ready) begin
                    o_res_valid = 1'b1;
                    n_st        = ST_RUN;
                    if (r_fire) begin
                        n_last  = w_dly;
                        n_cnt   = w_dly;
                        n_gate  = 1'b0;
                        n_armed = 1'b1;
                    end
                end
            end
            default: begin
                n_st = ST_RUN;
            end
        endcase
        o_res.gate            = n_gate;
        o_res.half_period_avg = fit_out(64'(r_avg));
        o_res.firing_delay    = fit_out(64'(n_last));
        o_res.timer_armed     = n_armed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= ST_RUN;
            r_ring_vld <= '0;
            r_pos      <= '0;
            r_sum      <= '0;
            r_since    <= '0;
            r_gate     <= 1'b0;
            r_cnt      <= '0;
            r_armed    <= 1'b0;
            r_last     <= '0;
            r_avg      <= '0;
        end else begin
            r_st    <= n_st;
            r_pos   <= n_pos;
            r_sum   <= n_sum;
            r_since <= n_since;
            r_gate  <= n_gate;
            r_cnt   <= n_cnt;
            r_armed <= n_armed;
            r_last  <= n_last;
            r_avg   <= n_avg;
            if (w_cross) begin
                r_ring_vld[r_pos] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cross) begin
            r_ring[r_pos] <= r_since;
            r_sp          <= i_cmd.sp;
            r_fire        <= (i_cmd.kind == K_FIRE);
        end
        r_prod  <= (2*SUM_W)'(r_sum) * (2*SUM_W)'(AVG_RECIP);
        r_prod2 <= PROD_W'(r_avg) * PROD_W'(SP_MAX - r_sp);
        r_prod3 <= (2*PROD_W)'(r_prod2) * (2*PROD_W)'(PCT_RECIP);
    end

endmodule

// ===== hw/rtl/patf_resq.sv =====
// Result queue between the back end and the output ports.
`timescale 1ns / 1ps
module patf_resq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  patf_pkg::t_res i_res,
    output logic           o_ready,
    output logic           empty,
    output patf_pkg::t_res o_res,
    input  logic           pop
);
    import patf_pkg::*;

    t_res                r_q [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] r_wr;
    logic [RQ_PTR_W-1:0] r_rd;
    logic [RQ_PTR_W:0]   r_cnt;
    logic [RQ_PTR_W:0]   n_cnt;
    logic                w_pop;

    assign o_ready = (r_cnt != (RQ_PTR_W+1)'(RQ_DEPTH));
    assign empty   = (r_cnt == '0);
    assign w_pop   = pop && !empty;
    assign o_res   = r_q[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !w_pop) begin
            n_cnt = r_cnt + (RQ_PTR_W+1)'(1);
        end else if (!i_push && w_pop) begin
            n_cnt = r_cnt - (RQ_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= r_wr + RQ_PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + RQ_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_res;
        end
    end

endmodule

// ===== hw/rtl/phase_angle_thyristor_firing.sv =====
// Top level: configuration registers, front end, back end and result queue.
// Ticks and disabled beats: one per cycle while the back end is idle and the
//   result queue has room. Zero crossings pass ST_MUL, ST_AVG, ST_DP and ST_DR (fire
//   only) and ST_FIN: the reciprocal-multiply divide chain for average and delay.
// Synchronous active-low reset clears queues, timers and ring valid bits at once
//   and loads the register defaults; no clearing pass, push is taken right after.
`timescale 1ns / 1ps
module phase_angle_thyristor_firing (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          i_mode,
    input  logic [patf_pkg::SP_W-1:0]     i_set_point,
    output logic                          empty,
    input  logic                          pop,
    output logic                          o_gate,
    output logic [patf_pkg::OUT_W-1:0]    o_half_period_avg,
    output logic [patf_pkg::OUT_W-1:0]    o_firing_delay,
    output logic                          o_timer_armed,
    input  logic                          i_cfg_we,
    input  logic [patf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [patf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import patf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DLY = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH  = CFG_IDX_W'(3);

    t_cfg r_cfg;
    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_cmd_pop;
    logic w_res_ready;
    logic w_res_valid;
    t_res w_res;
    t_res w_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable         <= 1'b0;
            r_cfg.pulse_width_us <= 16'd500;
            r_cfg.min_delay_us   <= 16'd100;
            r_cfg.fire_threshold <= SP_W'(10);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ENABLE:  r_cfg.enable         <= i_cfg_data[0];
                CFG_PULSE:   r_cfg.pulse_width_us <= i_cfg_data[15:0];
                CFG_MIN_DLY: r_cfg.min_delay_us   <= i_cfg_data[15:0];
                CFG_THRESH:  r_cfg.fire_threshold <= i_cfg_data[SP_W-1:0];
            endcase
        end
    end

    patf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_mode      (i_mode),
        .i_set_point (i_set_point),
        .i_cfg       (r_cfg),
        .full        (full),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    patf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_ready (w_res_ready),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    patf_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_res   (w_res),
        .o_ready (w_res_ready),
        .empty   (empty),
        .o_res   (w_head),
        .pop     (pop)
    );

    assign o_gate            = w_head.gate;
    assign o_half_period_avg = w_head.half_period_avg;
    assign o_firing_delay    = w_head.firing_delay;
    assign o_timer_armed     = w_head.timer_armed;

endmodule
